// File: rtl/chbd_pkg.sv
`timescale 1ns / 1ps

package chbd_pkg;

  // Result kinds, carried on m_tuser
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } chbd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
  } chbd_result_t;

endpackage

// File: rtl/chbd_step.sv
`timescale 1ns / 1ps

module chbd_step #(
  parameter int SIZE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  chbd_pkg::chbd_item_t  item,
  output logic                  res_valid,
  output chbd_pkg::chbd_result_t result
);
  import chbd_pkg::*;

  localparam logic [2:0] PH_SKIP = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_REST = 3'd2;
  localparam logic [2:0] PH_CR   = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_SP = 8'h20;

  // Returns {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [2:0]           phase, phase_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 digit_seen, digit_seen_next;

  logic [2:0]           cur_phase;
  logic [SIZE_BITS-1:0] cur_accum;
  logic [SIZE_BITS-1:0] cur_left;
  logic                 cur_seen;
  logic [4:0]           hex;
  logic [SIZE_BITS-1:0] accum_shift;
  logic                 overflow;
  logic [SIZE_BITS-1:0] left_after;
  logic [7:0]           c;

  always_comb begin
    // Restart applies before this byte
    cur_phase = item.restart ? PH_SKIP : phase;
    cur_accum = item.restart ? '0 : size_accum;
    cur_left  = item.restart ? '0 : bytes_left;
    cur_seen  = item.restart ? 1'b0 : digit_seen;

    c           = item.in_byte;
    hex         = hex_decode(c);
    accum_shift = {cur_accum[SIZE_BITS-5:0], hex[3:0]};
    overflow    = |cur_accum[SIZE_BITS-1:SIZE_BITS-4];
    left_after  = (cur_left != '0) ? cur_left - SIZE_BITS'(1) : cur_left;

    phase_next      = cur_phase;
    size_accum_next = cur_accum;
    bytes_left_next = cur_left;
    digit_seen_next = cur_seen;
    res_valid       = 1'b0;
    result.out_byte = 8'h00;
    result.kind     = KIND_DATA;

    case (cur_phase)
      PH_SKIP: begin
        if (c != CHAR_CR && c != CHAR_LF) begin
          size_accum_next = '0;
          digit_seen_next = 1'b0;
          if (c == CHAR_SP) begin
            phase_next = PH_SIZE;
          end else if (!hex[4]) begin
            phase_next  = PH_ERR;
            res_valid   = 1'b1;
            result.kind = KIND_ERR;
          end else begin
            size_accum_next = {{(SIZE_BITS-4){1'b0}}, hex[3:0]};
            digit_seen_next = 1'b1;
            phase_next      = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        if (hex[4]) begin
          if (overflow) begin
            phase_next  = PH_ERR;
            res_valid   = 1'b1;
            result.kind = KIND_ERR;
          end else begin
            size_accum_next = accum_shift;
            digit_seen_next = 1'b1;
          end
        end else if (!cur_seen) begin
          if (c != CHAR_SP) begin
            phase_next  = PH_ERR;
            res_valid   = 1'b1;
            result.kind = KIND_ERR;
          end
        end else begin
          phase_next = (c == CHAR_CR) ? PH_CR : PH_REST;
        end
      end
      PH_REST: begin
        if (c == CHAR_CR) begin
          phase_next = PH_CR;
        end
      end
      PH_CR: begin
        if (c != CHAR_CR) begin
          if (c != CHAR_LF) begin
            phase_next = PH_REST;
          end else if (cur_accum == '0) begin
            phase_next  = PH_DONE;
            res_valid   = 1'b1;
            result.kind = KIND_END;
          end else begin
            bytes_left_next = cur_accum;
            size_accum_next = '0;
            digit_seen_next = 1'b0;
            phase_next      = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next = left_after;
        if (left_after == '0) begin
          phase_next = PH_SKIP;
        end
        res_valid       = 1'b1;
        result.out_byte = c;
        result.kind     = KIND_DATA;
      end
      default: begin
        // done or error: drop bytes until restart
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      size_accum <= '0;
      bytes_left <= '0;
      digit_seen <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      size_accum <= size_accum_next;
      bytes_left <= bytes_left_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

// File: rtl/chbd_out_buf.sv
`timescale 1ns / 1ps

module chbd_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  chbd_pkg::chbd_result_t push_data,
  output logic                   ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output chbd_pkg::chbd_result_t m_data
);
  import chbd_pkg::*;

  logic         main_valid;
  chbd_result_t main_data;
  logic         skid_valid;
  chbd_result_t skid_data;

  assign ready    = !skid_valid;
  assign m_tvalid = main_valid;
  assign m_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !main_valid) begin
      // Main slot frees up: refill from skid first
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

// File: rtl/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps

// HTTP chunked body decoder: takes one body byte per request on the slave side
// and returns only the chunk data bytes on the master side, plus one end request
// when the zero-size chunk line completes and one error request on a bad or
// oversized size line. Raise s_tuser with a byte to start a new body. A byte is
// taken every cycle while the output buffer has room; it passes an input register,
// the parse step, whose state update is the loop that sets the one-byte-per-cycle
// rate, and the output buffer before its result is offered on the master side.
// Sizes up to 2^SIZE_BITS - 1 are accepted. No clearing pass follows reset.

module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] restart
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser    // [1:0] kind
);
  import chbd_pkg::*;

  logic         in_valid;
  chbd_item_t   in_item;
  logic         advance;
  logic         buf_ready;
  logic         res_valid;
  chbd_result_t result;
  chbd_result_t m_data;

  assign advance  = in_valid && buf_ready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.in_byte <= s_tdata;
      in_item.restart <= s_tuser;
    end
  end

  chbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_item),
    .res_valid(res_valid),
    .result   (result)
  );

  chbd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && res_valid),
    .push_data(result),
    .ready    (buf_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_data   (m_data)
  );

  assign m_tdata = m_data.out_byte;
  assign m_tuser = m_data.kind;

endmodule
